// ----- hw/rtl/ivf_sd_pkg.sv -----
// ----------------------------------------------------------------------------
// IVF deframer package
// Shared codes, container tags and the result beat layout.
// ----------------------------------------------------------------------------
package ivf_sd_pkg;

  localparam int unsigned CFG_W      = 29;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned DATA_W     = 32;

  // Register indexes (paddr[2])
  localparam logic REG_MAX_FRAME_BYTES = 1'b0;

  localparam logic [CFG_W-1:0] HARD_MAX_FRAME = 29'h1000_0000;

  // Four-character tags as read little-endian from four header bytes
  localparam logic [31:0] TAG_DKIF = 32'h4649_4B44;
  localparam logic [31:0] TAG_VP80 = 32'h3038_5056;
  localparam logic [31:0] TAG_VP90 = 32'h3039_5056;
  localparam logic [31:0] TAG_AV01 = 32'h3130_5641;

  localparam logic [1:0] KIND_INFO   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_BYTE   = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] CODEC_VP8 = 2'd0;
  localparam logic [1:0] CODEC_VP9 = 2'd1;
  localparam logic [1:0] CODEC_AV1 = 2'd2;

  localparam logic [1:0] ST_INVALID     = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_EOF         = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       codec;
    logic [15:0]      width;
    logic [15:0]      height;
    logic [31:0]      rate;
    logic [31:0]      scale;
    logic [31:0]      frame_total;
    logic [CFG_W-1:0] frame_bytes;
    logic [63:0]      frame_time;
    logic [7:0]       payload_byte;
    logic             last_of_frame;
    logic [1:0]       status;
  } res_t;

endpackage

// ----- hw/rtl/ivf_stream_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// IVF stream deframer
// Parses an IVF container byte stream into header info, frames and status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one beat per container byte, or a beat
//   with in_stream_end high to mark the end of the stream.
//   Output channel (out_valid/out_ready): zero or one result beat per input
//   beat: file header info, frame start (size and timestamp), payload byte
//   with last_of_frame, or a status (invalid, unsupported codec, eof).
//   After any status the block drops all input until reset.
//   Config: max_frame_bytes at byte address 0 of the APB-style port; write it
//   only while the stream is idle.
// Timing:
//   One input beat per cycle while in_ready is high; the per-byte work sits
//   between the parser state and the result register, so each result is
//   registered. Throughput is one byte per cycle while out_ready is high.
//   A result register plus one skid entry holds output under a stall;
//   in_ready drops only once the skid entry is full.
// Reset (rst_n, synchronous): parser returns to the file header phase,
//   output beats are cleared and max_frame_bytes goes to 268435456.
// ----------------------------------------------------------------------------
module ivf_stream_deframer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // input beats
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_byte,
  input  logic                               in_stream_end,
  // result beats
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_kind,
  output logic [1:0]                         out_codec,
  output logic [15:0]                        out_width,
  output logic [15:0]                        out_height,
  output logic [31:0]                        out_rate,
  output logic [31:0]                        out_scale,
  output logic [31:0]                        out_frame_total,
  output logic [ivf_sd_pkg::CFG_W-1:0]       out_frame_bytes,
  output logic [63:0]                        out_frame_time,
  output logic [7:0]                         out_payload_byte,
  output logic                               out_last_of_frame,
  output logic [1:0]                         out_status,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ivf_sd_pkg::PADDR_W-1:0]     paddr,
  input  logic [ivf_sd_pkg::DATA_W-1:0]      pwdata,
  output logic [ivf_sd_pkg::DATA_W-1:0]      prdata,
  output logic                               pready
);
  import ivf_sd_pkg::*;

  logic [CFG_W-1:0] max_frame_r;
  logic             cfg_wr;
  logic             in_accept;
  logic             res_valid;
  res_t             res;
  res_t             out_data;

  // Configuration register: written in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_FRAME_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= HARD_MAX_FRAME;
    end else if (cfg_wr) begin
      max_frame_r <= pwdata[CFG_W-1:0];
    end
  end

  // Reads of unmapped addresses return zero
  assign prdata = (paddr[2] == REG_MAX_FRAME_BYTES) ?
                  {{(DATA_W-CFG_W){1'b0}}, max_frame_r} : '0;

  // Accept whenever the skid entry is free
  assign in_accept = in_valid && in_ready;

  ivf_sd_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .in_byte         (in_byte),
    .in_stream_end   (in_stream_end),
    .max_frame_bytes (max_frame_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  ivf_sd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Fan the result beat out to its field ports
  assign out_kind          = out_data.kind;
  assign out_codec         = out_data.codec;
  assign out_width         = out_data.width;
  assign out_height        = out_data.height;
  assign out_rate          = out_data.rate;
  assign out_scale         = out_data.scale;
  assign out_frame_total   = out_data.frame_total;
  assign out_frame_bytes   = out_data.frame_bytes;
  assign out_frame_time    = out_data.frame_time;
  assign out_payload_byte  = out_data.payload_byte;
  assign out_last_of_frame = out_data.last_of_frame;
  assign out_status        = out_data.status;

endmodule

// ----- hw/rtl/ivf_sd_parser.sv -----
// ----------------------------------------------------------------------------
// IVF deframer parser
// Phase tracking, header capture and checks; one result per byte at most.
// ----------------------------------------------------------------------------
module ivf_sd_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [7:0]                in_byte,
  input  logic                      in_stream_end,
  input  logic [ivf_sd_pkg::CFG_W-1:0] max_frame_bytes,
  output logic                      res_valid,
  output ivf_sd_pkg::res_t          res
);
  import ivf_sd_pkg::*;

  typedef enum logic [4:0] {
    PH_FILEHDR  = 5'b00001,
    PH_SKIP     = 5'b00010,
    PH_FRAMEHDR = 5'b00100,
    PH_PAYLOAD  = 5'b01000,
    PH_DONE     = 5'b10000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [15:0]      skip_r, skip_nxt;
  logic [CFG_W-1:0] pay_r, pay_nxt;
  logic [7:0]       store_r [32];
  logic             wr_en;

  logic [31:0] magic, fourcc, rate_w, scale_w, total_w, size_w;
  logic [15:0] hdr_len, width_w, height_w;
  logic [63:0] stamp_w;
  logic        size_bad;

  assign magic    = {store_r[3], store_r[2], store_r[1], store_r[0]};
  assign hdr_len  = {store_r[7], store_r[6]};
  assign fourcc   = {store_r[11], store_r[10], store_r[9], store_r[8]};
  assign width_w  = {store_r[13], store_r[12]};
  assign height_w = {store_r[15], store_r[14]};
  assign rate_w   = {store_r[19], store_r[18], store_r[17], store_r[16]};
  assign scale_w  = {store_r[23], store_r[22], store_r[21], store_r[20]};
  assign total_w  = {store_r[27], store_r[26], store_r[25], store_r[24]};
  // frame header view: the final timestamp byte is the one arriving now
  assign size_w   = magic;
  assign stamp_w  = {in_byte, store_r[10], store_r[9], store_r[8],
                     store_r[7], store_r[6], store_r[5], store_r[4]};
  assign size_bad = (size_w == 32'd0) ||
                    (size_w > {3'b000, max_frame_bytes}) ||
                    (size_w > {3'b000, HARD_MAX_FRAME});

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    skip_nxt  = skip_r;
    pay_nxt   = pay_r;
    wr_en     = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    if (accept) begin
      case (phase_r)
        PH_FILEHDR: begin
          if (in_stream_end) begin
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_INVALID;
            phase_nxt  = PH_DONE;
          end else begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + 5'd1;
            if (cnt_r == 5'd31) begin
              res_valid = 1'b1;
              if (magic != TAG_DKIF || hdr_len < 16'd32) begin
                res.kind   = KIND_STATUS;
                res.status = ST_INVALID;
                phase_nxt  = PH_DONE;
              end else if (fourcc != TAG_VP80 && fourcc != TAG_VP90 &&
                           fourcc != TAG_AV01) begin
                res.kind   = KIND_STATUS;
                res.status = ST_UNSUPPORTED;
                phase_nxt  = PH_DONE;
              end else if (width_w == 16'd0 || height_w == 16'd0 ||
                           rate_w == 32'd0 || scale_w == 32'd0) begin
                res.kind   = KIND_STATUS;
                res.status = ST_INVALID;
                phase_nxt  = PH_DONE;
              end else begin
                res.kind        = KIND_INFO;
                res.codec       = (fourcc == TAG_VP80) ? CODEC_VP8 :
                                  (fourcc == TAG_VP90) ? CODEC_VP9 : CODEC_AV1;
                res.width       = width_w;
                res.height      = height_w;
                res.rate        = rate_w;
                res.scale       = scale_w;
                res.frame_total = total_w;
                skip_nxt        = hdr_len - 16'd32;
                phase_nxt       = (hdr_len != 16'd32) ? PH_SKIP : PH_FRAMEHDR;
              end
            end
          end
        end
        PH_SKIP: begin
          if (in_stream_end) begin
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_EOF;
            phase_nxt  = PH_DONE;
          end else begin
            skip_nxt = skip_r - 16'd1;
            if (skip_r == 16'd1) begin
              phase_nxt = PH_FRAMEHDR;
            end
          end
        end
        PH_FRAMEHDR: begin
          if (in_stream_end) begin
            res_valid  = 1'b1;
            res.kind   = KIND_STATUS;
            res.status = ST_EOF;
            phase_nxt  = PH_DONE;
          end else begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + 5'd1;
            if (cnt_r == 5'd11) begin
              cnt_nxt   = 5'd0;
              res_valid = 1'b1;
              if (size_bad) begin
                res.kind   = KIND_STATUS;
                res.status = ST_INVALID;
                phase_nxt  = PH_DONE;
              end else begin
                res.kind        = KIND_START;
                res.frame_bytes = size_w[CFG_W-1:0];
                res.frame_time  = stamp_w;
                pay_nxt         = size_w[CFG_W-1:0];
                phase_nxt       = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          if (in_stream_end) begin
            res.kind   = KIND_STATUS;
            res.status = ST_INVALID;
            phase_nxt  = PH_DONE;
          end else begin
            res.kind          = KIND_BYTE;
            res.payload_byte  = in_byte;
            res.last_of_frame = (pay_r <= 29'd1);
            if (pay_r <= 29'd1) begin
              pay_nxt   = '0;
              phase_nxt = PH_FRAMEHDR;
            end else begin
              pay_nxt = pay_r - 29'd1;
            end
          end
        end
        default: begin
          // done: drop everything until reset
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FILEHDR;
      cnt_r   <= '0;
      skip_r  <= '0;
      pay_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
      pay_r   <= pay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[cnt_r] <= in_byte;
    end
  end

endmodule

// ----- hw/rtl/ivf_sd_outbuf.sv -----
// ----------------------------------------------------------------------------
// IVF deframer output buffer
// Result register plus skid stage so input keeps flowing under a stall until the skid entry is full.
// ----------------------------------------------------------------------------
module ivf_sd_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ivf_sd_pkg::res_t push_data,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output ivf_sd_pkg::res_t out_data
);
  import ivf_sd_pkg::*;

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t main_d_r, skid_d_r;
  logic pop;

  assign pop       = main_v_r && out_ready;
  assign can_take  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (pop || !main_v_r) begin
      main_v_nxt = skid_v_r || push;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !main_v_r) begin
      main_d_r <= skid_v_r ? skid_d_r : push_data;
    end else if (push) begin
      skid_d_r <= push_data;
    end
  end

endmodule

// ----- verif/tb_ivf_stream_deframer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IVF stream deframer testbench
// Feeds one continuous IVF stream through the deframer: a file header with
// extra header bytes, directed frames at the field extremes, frames at the
// max_frame_bytes limit, then a few dozen random frames with one limit
// change. The run closes with one randomly chosen terminating condition and
// trailing input that must be dropped. A local parser model predicts every
// result beat; a scoreboard checks each accepted beat field by field.
// ----------------------------------------------------------------------------
module tb_ivf_stream_deframer_unit;
  import ivf_sd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BEATS  = 420;
  localparam int MAX_PRINTS    = 30;
  localparam logic [PADDR_W-1:0] MAX_BYTES_ADDR = {REG_MAX_FRAME_BYTES, 2'b00};

  // parser phases of the local model
  typedef enum logic [2:0] {
    PH_FILE_HDR, PH_SKIP, PH_FRAME_HDR, PH_PAYLOAD, PH_DONE
  } parse_phase_t;

  // ways the stream is closed at the end of the run
  typedef enum int {
    END_AT_BOUNDARY, END_IN_FRAME_HDR, END_IN_PAYLOAD,
    END_ZERO_SIZE, END_OVER_LIMIT, END_OVER_HARD_MAX
  } close_mode_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte = '0;
  logic               in_stream_end = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_kind;
  logic [1:0]         out_codec;
  logic [15:0]        out_width;
  logic [15:0]        out_height;
  logic [31:0]        out_rate;
  logic [31:0]        out_scale;
  logic [31:0]        out_frame_total;
  logic [CFG_W-1:0]   out_frame_bytes;
  logic [63:0]        out_frame_time;
  logic [7:0]         out_payload_byte;
  logic               out_last_of_frame;
  logic [1:0]         out_status;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  ivf_stream_deframer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .in_stream_end     (in_stream_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_codec         (out_codec),
    .out_width         (out_width),
    .out_height        (out_height),
    .out_rate          (out_rate),
    .out_scale         (out_scale),
    .out_frame_total   (out_frame_total),
    .out_frame_bytes   (out_frame_bytes),
    .out_frame_time    (out_frame_time),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_status        (out_status),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Scoreboard state and the local copy of the parser
  // --------------------------------------------------------------------------
  res_t         expected_beats [$];
  int           err_count      = 0;
  int           results_seen   = 0;
  int           beats_sent     = 0;
  int           frames_sent    = 0;
  int           cycle_count    = 0;
  bit           src_gaps       = 1'b0;
  bit           sink_gaps      = 1'b0;
  int           sink_hold      = 0;
  int           sink_draw;
  close_mode_t  close_mode;

  parse_phase_t ph;
  logic [15:0]  hdr_count;
  logic [7:0]   hdr_bytes [32];
  logic [15:0]  skip_left;
  logic [28:0]  payload_left;
  logic [28:0]  max_bytes;

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic log_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic logic [15:0] hdr_le16(input int pos);
    return {hdr_bytes[(pos + 1) & 31], hdr_bytes[pos & 31]};
  endfunction

  function automatic logic [31:0] hdr_le32(input int pos);
    return {hdr_le16(pos + 2), hdr_le16(pos)};
  endfunction

  function automatic res_t status_beat(input logic [1:0] code);
    res_t r;
    r        = '0;
    r.kind   = KIND_STATUS;
    r.status = code;
    return r;
  endfunction

  // Advance the local parser by one accepted beat and queue what it emits.
  task automatic deframe_predict(input logic [7:0] b, input logic is_end);
    res_t        r;
    bit          emits;
    bit          known;
    logic [15:0] hlen;
    logic [31:0] fcc;
    logic [31:0] fsize;
    logic [1:0]  cdc;
    r     = '0;
    emits = 1'b0;
    known = 1'b1;
    cdc   = CODEC_VP8;
    if (ph != PH_DONE) begin
      if (is_end) begin
        // ending mid file header or mid payload is broken, elsewhere it is eof
        emits = 1'b1;
        r = status_beat((ph == PH_FILE_HDR || ph == PH_PAYLOAD) ? ST_INVALID : ST_EOF);
        ph = PH_DONE;
      end else begin
        case (ph)
          PH_FILE_HDR: begin
            hdr_bytes[hdr_count[4:0]] = b;
            hdr_count = hdr_count + 16'd1;
            if (hdr_count >= 16'd32) begin
              emits = 1'b1;
              hlen  = hdr_le16(6);
              fcc   = hdr_le32(8);
              if (hdr_le32(0) != TAG_DKIF || hlen < 16'd32) begin
                r  = status_beat(ST_INVALID);
                ph = PH_DONE;
              end else begin
                if (fcc == TAG_VP80)      cdc = CODEC_VP8;
                else if (fcc == TAG_VP90) cdc = CODEC_VP9;
                else if (fcc == TAG_AV01) cdc = CODEC_AV1;
                else                      known = 1'b0;
                if (!known) begin
                  r  = status_beat(ST_UNSUPPORTED);
                  ph = PH_DONE;
                end else if (hdr_le16(12) == 0 || hdr_le16(14) == 0 ||
                             hdr_le32(16) == 0 || hdr_le32(20) == 0) begin
                  r  = status_beat(ST_INVALID);
                  ph = PH_DONE;
                end else begin
                  r.kind        = KIND_INFO;
                  r.codec       = cdc;
                  r.width       = hdr_le16(12);
                  r.height      = hdr_le16(14);
                  r.rate        = hdr_le32(16);
                  r.scale       = hdr_le32(20);
                  r.frame_total = hdr_le32(24);
                  skip_left     = hlen - 16'd32;
                  hdr_count     = '0;
                  ph            = (skip_left != 0) ? PH_SKIP : PH_FRAME_HDR;
                end
              end
            end
          end
          PH_SKIP: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 0) ph = PH_FRAME_HDR;
          end
          PH_FRAME_HDR: begin
            hdr_bytes[hdr_count[4:0]] = b;
            hdr_count = hdr_count + 16'd1;
            if (hdr_count >= 16'd12) begin
              emits     = 1'b1;
              fsize     = hdr_le32(0);
              hdr_count = '0;
              if (fsize == 0 || fsize > max_bytes || fsize > HARD_MAX_FRAME) begin
                r  = status_beat(ST_INVALID);
                ph = PH_DONE;
              end else begin
                r.kind        = KIND_START;
                r.frame_bytes = fsize[28:0];
                r.frame_time  = {hdr_le32(8), hdr_le32(4)};
                payload_left  = fsize[28:0];
                ph            = PH_PAYLOAD;
              end
            end
          end
          default: begin
            emits              = 1'b1;
            r.kind             = KIND_BYTE;
            r.payload_byte     = b;
            r.last_of_frame    = (payload_left <= 1);
            if (payload_left <= 1) begin
              payload_left = '0;
              ph           = PH_FRAME_HDR;
            end else begin
              payload_left = payload_left - 29'd1;
            end
          end
        endcase
      end
    end
    if (emits) expected_beats.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each accepted beat against the oldest expectation,
  // then draw a stall before taking the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b1;
      sink_hold <= 0;
    end else if (out_valid && out_ready) begin
      results_seen++;
      if (expected_beats.size() == 0) begin
        log_mismatch($sformatf("result beat with nothing expected, kind %0h", out_kind));
      end else begin
        want = expected_beats.pop_front();
        check_field("kind",          out_kind,          want.kind);
        check_field("codec",         out_codec,         want.codec);
        check_field("width",         out_width,         want.width);
        check_field("height",        out_height,        want.height);
        check_field("rate",          out_rate,          want.rate);
        check_field("scale",         out_scale,         want.scale);
        check_field("frame_total",   out_frame_total,   want.frame_total);
        check_field("frame_bytes",   out_frame_bytes,   want.frame_bytes);
        check_field("frame_time",    out_frame_time,    want.frame_time);
        check_field("payload_byte",  out_payload_byte,  want.payload_byte);
        check_field("last_of_frame", out_last_of_frame, want.last_of_frame);
        check_field("status",        out_status,        want.status);
      end
      sink_draw = sink_gaps ? $urandom_range(0, 16) : 0;
      if (sink_draw != 0) begin
        out_ready <= 1'b0;
        sink_hold <= sink_draw;
      end
    end else if (sink_hold != 0) begin
      // release out_ready once the drawn stall has run out
      sink_hold <= sink_hold - 1;
      if (sink_hold == 1) out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run once the cycle count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Send one beat: draw an idle gap, present the beat, hold it until accepted.
  // in_valid is only dropped when a gap follows, so back-to-back beats never
  // see a low and a high assignment in the same step.
  task automatic drive_beat(input logic [7:0] b, input logic is_end);
    int gap;
    gap = src_gaps ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    in_stream_end <= is_end;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    deframe_predict(b, is_end);
  endtask

  // Hold off the sender until every expected result is back, then let the
  // pipeline run dry (frame header bytes emit nothing).
  task automatic settle_stream();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == MAX_BYTES_ADDR) max_bytes = data[28:0];
  endtask

  task automatic cfg_read_check(input logic [PADDR_W-1:0] addr);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("max_frame_bytes readback", prdata[28:0], max_bytes);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Pick 1, the top value or something in between for a header field.
  function automatic logic [31:0] pick_extreme(input logic [31:0] top);
    case ($urandom_range(0, 2))
      0:       return 32'd1;
      1:       return top;
      default: return $urandom_range(top, 1);
    endcase
  endfunction

  function automatic int size_cap(input int ceiling);
    return (max_bytes < ceiling) ? int'(max_bytes) : ceiling;
  endfunction

  // Send the first nbytes of a 12-byte frame header.
  task automatic send_frame_header(input logic [31:0] fsize, input logic [63:0] stamp,
                                   input int nbytes);
    logic [95:0] bits;
    bits = {stamp, fsize};
    for (int i = 0; i < nbytes; i++) drive_beat(bits[8*i +: 8], 1'b0);
  endtask

  task automatic send_payload(input int n);
    for (int i = 0; i < n; i++) drive_beat(8'($urandom), 1'b0);
  endtask

  task automatic send_frame(input int fsize);
    send_frame_header(fsize, {$urandom, $urandom}, 12);
    send_payload(fsize);
    frames_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Register reset value, the widest value and restore of the hard limit.
  task automatic test_register_access();
    cfg_read_check(MAX_BYTES_ADDR);
    cfg_write(MAX_BYTES_ADDR, 32'h1FFF_FFFF);
    cfg_read_check(MAX_BYTES_ADDR);
    cfg_write(MAX_BYTES_ADDR, 32'(HARD_MAX_FRAME));
    cfg_read_check(MAX_BYTES_ADDR);
  endtask

  // One well-formed file header with random codec, extreme picture fields
  // and a few extra header bytes to skip.
  task automatic test_file_header();
    logic [255:0] fh;
    logic [15:0]  extra;
    logic [31:0]  fourcc;
    case ($urandom_range(0, 2))
      0:       fourcc = TAG_VP80;
      1:       fourcc = TAG_VP90;
      default: fourcc = TAG_AV01;
    endcase
    extra          = $urandom_range(1, 6);
    fh             = {$urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom};
    fh[31:0]       = TAG_DKIF;
    fh[63:48]      = 16'd32 + extra;
    fh[95:64]      = fourcc;
    fh[111:96]     = 16'(pick_extreme(32'hFFFF));
    fh[127:112]    = 16'(pick_extreme(32'hFFFF));
    fh[159:128]    = pick_extreme(32'hFFFF_FFFF);
    fh[191:160]    = pick_extreme(32'hFFFF_FFFF);
    src_gaps       = 1'b1;
    sink_gaps      = 1'b1;
    for (int i = 0; i < 32; i++) drive_beat(fh[8*i +: 8], 1'b0);
    send_payload(extra);
  endtask

  // Smallest frames, timestamp extremes and payload byte extremes.
  task automatic test_frame_extremes();
    send_frame_header(32'd1, 64'h0, 12);
    drive_beat(8'h00, 1'b0);
    send_frame_header(32'd2, 64'hFFFF_FFFF_FFFF_FFFF, 12);
    drive_beat(8'hFF, 1'b0);
    drive_beat(8'h80, 1'b0);
    frames_sent += 2;
  endtask

  // Frames exactly at the limit, with the lowest limit and a mid one.
  task automatic test_frame_size_limit();
    settle_stream();
    cfg_write(MAX_BYTES_ADDR, 32'd1);
    cfg_read_check(MAX_BYTES_ADDR);
    send_frame(1);
    send_frame(1);
    settle_stream();
    cfg_write(MAX_BYTES_ADDR, $urandom_range(2, 24));
    send_frame(int'(max_bytes));
  endtask

  // Random frames with random content; mostly short, some longer. Idling
  // is switched per frame so some frames run without any gaps.
  task automatic test_random_frames();
    int  stop_at;
    int  half_at;
    bit  relimited;
    int  fsize;
    stop_at   = beats_sent + RANDOM_BEATS;
    half_at   = beats_sent + RANDOM_BEATS / 2;
    relimited = 1'b0;
    while (beats_sent < stop_at) begin
      if (!relimited && beats_sent >= half_at) begin
        // pause the sender until the block has drained, then move the limit
        relimited = 1'b1;
        settle_stream();
        case ($urandom_range(0, 2))
          0:       cfg_write(MAX_BYTES_ADDR, $urandom_range(4, 20));
          1:       cfg_write(MAX_BYTES_ADDR, 32'h1FFF_FFFF);
          default: cfg_write(MAX_BYTES_ADDR, 32'(HARD_MAX_FRAME));
        endcase
        cfg_read_check(MAX_BYTES_ADDR);
      end
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 15))
        0:       fsize = size_cap(48);
        1, 2:    fsize = $urandom_range(1, size_cap(48));
        default: fsize = $urandom_range(1, size_cap(8));
      endcase
      send_frame(fsize);
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // Close the stream one way, then feed trailing beats that must be dropped.
  task automatic test_stream_close();
    int fsize;
    close_mode = close_mode_t'($urandom_range(0, 5));
    $display("closing stream: %s", close_mode.name());
    case (close_mode)
      END_AT_BOUNDARY: drive_beat(8'($urandom), 1'b1);
      END_IN_FRAME_HDR: begin
        send_frame_header({$urandom}, {$urandom, $urandom}, $urandom_range(1, 11));
        drive_beat(8'($urandom), 1'b1);
      end
      END_IN_PAYLOAD: begin
        fsize = $urandom_range(1, size_cap(10));
        send_frame_header(fsize, {$urandom, $urandom}, 12);
        send_payload($urandom_range(0, fsize - 1));
        drive_beat(8'($urandom), 1'b1);
      end
      END_ZERO_SIZE: send_frame_header(32'd0, {$urandom, $urandom}, 12);
      END_OVER_LIMIT: begin
        settle_stream();
        cfg_write(MAX_BYTES_ADDR, $urandom_range(1, 30));
        send_frame_header(max_bytes + 1 + $urandom_range(0, 100), {$urandom, $urandom}, 12);
      end
      default: begin
        // the register allows more than the hard limit; the hard limit wins
        settle_stream();
        cfg_write(MAX_BYTES_ADDR, 32'h1FFF_FFFF);
        send_frame_header($urandom_range(32'hFFFF_FFFF, 32'h1000_0001),
                          {$urandom, $urandom}, 12);
      end
    endcase
    for (int i = 0; i < 12; i++) drive_beat(8'($urandom), (i == 11) || $urandom_range(0, 1));
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    ph           = PH_FILE_HDR;
    hdr_count    = '0;
    skip_left    = '0;
    payload_left = '0;
    max_bytes    = HARD_MAX_FRAME;
    for (int i = 0; i < 32; i++) hdr_bytes[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_file_header();
    test_frame_extremes();
    test_frame_size_limit();
    test_random_frames();
    test_stream_close();

    settle_stream();
    repeat (16) @(posedge clk);

    $display("sent %0d beats in %0d complete frames, checked %0d result beats",
             beats_sent, frames_sent, results_seen);
    $display("stream closed by %s, limit changes and idle gaps on both sides",
             close_mode.name());
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", err_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
